// ===== rtl/core/nfassim_pkg.sv =====
// Shared types, codes and defaults for the NFA state-set simulator.
`default_nettype none

package nfassim_pkg;

  localparam int DEF_MAX_STATES  = 16;
  localparam int DEF_MAX_SYMBOLS = 8;

  // Fixed field widths of the streaming payload.
  localparam int CMD_W    = 2;
  localparam int SRC_W    = 4;
  localparam int SYM_W    = 3;
  localparam int TARGET_W = 16;
  localparam int CHAR_W   = 8;
  localparam int SET_W    = 16;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK   = 2'd3;
  localparam int CFG_DATA_W = 64;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYMBOL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STEPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

  // Transition row write broadcast to every cell.
  typedef struct packed {
    logic                en;
    logic [SRC_W-1:0]    src;
    logic [SYM_W-1:0]    sym;
    logic [TARGET_W-1:0] target;
  } row_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/nfassim_cell.sv =====
// One state cell: holds the transition rows of its state and ORs them into the chain.
`default_nettype none

module nfassim_cell
  import nfassim_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int CELL_ID     = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire row_wr_t               wr,
  input  wire logic [SYM_W-1:0]      sel,
  input  wire logic                  active,
  input  wire logic [MAX_STATES-1:0] acc_in,
  output logic      [MAX_STATES-1:0] acc_out
);

  localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [MAX_STATES-1:0] rows_r [MAX_SYMBOLS];
  logic [MAX_STATES-1:0] acc_r;
  logic [MAX_STATES-1:0] wr_row;
  logic                  wr_hit;

  // Targets are cut or zero-extended to the states the table can hold.
  for (genvar b = 0; b < MAX_STATES; b++) begin : g_row
    if (b < TARGET_W) begin : g_in
      assign wr_row[b] = wr.target[b];
    end else begin : g_zero
      assign wr_row[b] = 1'b0;
    end
  end

  assign wr_hit = wr.en && (int'(wr.src) == CELL_ID) && (int'(wr.sym) < MAX_SYMBOLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        rows_r[k] <= '0;
      end
    end else if (wr_hit) begin
      rows_r[wr.sym[SW-1:0]] <= wr_row;
    end
  end

  // The partial OR moves one cell further down the chain every cycle.
  always_ff @(posedge clk) begin
    acc_r <= acc_in | (active ? rows_r[sel[SW-1:0]] : '0);
  end

  assign acc_out = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/nfa_state_set_simulator_unit.sv =====
// Top level of the NFA state-set simulator: command handling, configuration and cell chain.
`default_nettype none

// Runs a nondeterministic automaton over a character stream, one command per
// input transfer and one result transfer per command. Load, start and finish
// commands and symbols that hit the error path go from the accepted transfer
// to the result state and back to idle before the next transfer is taken; a
// stepping symbol first sweeps the row of state cells, through which the next
// active set is ORed one cell per cycle. Results wait in an output register, so
// a stalled result side holds the block only once that register is full.
// Configuration writes are always taken and act in the next cycle.
module nfa_state_set_simulator_unit
  import nfassim_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata, low bit up: src_state[3:0], sym_index[6:4], target_mask[22:7],
  // character[30:23], zero fill[31].
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [CMD_W-1:0]      in_tuser,   // cmd
  // Result channel.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // active_set
  output logic [STATUS_W-1:0]        out_tuser,  // status
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_STATES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  // Configuration registers.
  logic [4:0]            state_count_r;
  logic [3:0]            symbol_count_r;
  logic [63:0]           alphabet_r;
  logic [15:0]           final_mask_r;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [MAX_STATES-1:0] active_r, active_nxt;
  logic                  err_r, err_nxt;
  logic [SYM_W-1:0]      sel_r, sel_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_set_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic                  in_fire;
  logic [CMD_W-1:0]      cmd;
  logic [CHAR_W-1:0]     in_char;
  row_wr_t               wr;

  logic [MAX_STATES-1:0] use_mask;
  logic [MAX_STATES-1:0] final_ext;
  logic [OUT_DATA_W-1:0] set_low;
  logic                  sym_found;
  logic [SYM_W-1:0]      sym_idx;
  logic                  out_load;

  logic [MAX_STATES-1:0] chain [MAX_STATES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r  <= 5'd16;
      symbol_count_r <= 4'd8;
      alphabet_r     <= '0;
      final_mask_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STATE_COUNT:  state_count_r  <= cfg_data[4:0];
        CFG_SYMBOL_COUNT: symbol_count_r <= cfg_data[3:0];
        CFG_ALPHABET:     alphabet_r     <= cfg_data;
        CFG_FINAL_MASK:   final_mask_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign in_char   = in_tdata[30:23];

  assign wr.en     = in_fire && (cmd == CMD_LOAD);
  assign wr.src    = in_tdata[3:0];
  assign wr.sym    = in_tdata[6:4];
  assign wr.target = in_tdata[22:7];

  // States in use, with the count saturated to 1..MAX_STATES.
  always_comb begin
    int n;
    n = int'(state_count_r);
    if (n < 1) n = 1;
    if (n > MAX_STATES) n = MAX_STATES;
    for (int b = 0; b < MAX_STATES; b++) begin
      use_mask[b] = (b < n);
    end
  end

  for (genvar b = 0; b < MAX_STATES; b++) begin : g_final
    if (b < 16) begin : g_in
      assign final_ext[b] = final_mask_r[b];
    end else begin : g_zero
      assign final_ext[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < OUT_DATA_W; b++) begin : g_set
    if (b < MAX_STATES) begin : g_in
      assign set_low[b] = active_r[b];
    end else begin : g_zero
      assign set_low[b] = 1'b0;
    end
  end

  // Alphabet lookup; scanning downward lets the lowest matching index win.
  always_comb begin
    int m;
    m = int'(symbol_count_r);
    if (m < 1) m = 1;
    if (m > MAX_SYMBOLS) m = MAX_SYMBOLS;
    sym_found = 1'b0;
    sym_idx   = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if (k < m && alphabet_r[8*k +: 8] == in_char) begin
        sym_found = 1'b1;
        sym_idx   = SYM_W'(k);
      end
    end
  end

  // Cell chain.
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
    nfassim_cell #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .CELL_ID     (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .sel     (sel_r),
      .active  (active_r[i] & use_mask[i]),
      .acc_in  (chain[i]),
      .acc_out (chain[i+1])
    );
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    active_nxt      = active_r;
    err_nxt         = err_r;
    sel_nxt         = sel_r;
    pend_status_nxt = pend_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt       = S_DONE;
          pend_status_nxt = ST_ACK;
          case (cmd)
            CMD_LOAD: ;
            CMD_START: begin
              active_nxt = MAX_STATES'(1);
              err_nxt    = 1'b0;
            end
            CMD_SYMBOL: begin
              pend_status_nxt = ST_UNKNOWN;
              if (!err_r) begin
                if (!sym_found) begin
                  err_nxt = 1'b1;
                end else begin
                  sel_nxt   = sym_idx;
                  cnt_nxt   = '0;
                  state_nxt = S_SWEEP;
                end
              end
            end
            CMD_FINISH: begin
              if (err_r) begin
                pend_status_nxt = ST_INVALID;
              end else if ((active_r & final_ext & use_mask) != '0) begin
                pend_status_nxt = ST_ACCEPTED;
              end else begin
                pend_status_nxt = ST_REJECTED;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        // The last cell holds the full OR once every cell has been passed.
        if (cnt_r == CNT_W'(MAX_STATES)) begin
          active_nxt      = chain[MAX_STATES] & use_mask;
          pend_status_nxt = ST_STEPPED;
          state_nxt       = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= MAX_STATES'(1);
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      err_r    <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r         <= sel_nxt;
    pend_status_r <= pend_status_nxt;
    if (out_load) begin
      out_set_r    <= set_low;
      out_status_r <= pend_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_set_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== sim/tb_nfa_state_set_simulator_unit.sv =====
// Self-checking testbench for the NFA state-set simulator: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module tb_nfa_state_set_simulator_unit
  import nfassim_pkg::*;
();

  localparam int DRAIN_CYCLES = DEF_MAX_STATES + 8;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [SET_W-1:0]    active_set;
    logic [STATUS_W-1:0] status;
  } nfa_result_t;

  // Tracks the automaton the way the block should, one command per accepted transfer.
  class nfa_tracker;
    logic [TARGET_W-1:0] rows [DEF_MAX_STATES * DEF_MAX_SYMBOLS];
    logic [SET_W-1:0]    active;
    bit                  string_bad;
    logic [4:0]          state_count;
    logic [3:0]          symbol_count;
    logic [63:0]         alphabet;
    logic [15:0]         accept_mask;
    nfa_result_t         results_due [$];
    int                  errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      active       = 16'h0001;
      string_bad   = 1'b0;
      state_count  = 5'd16;
      symbol_count = 4'd8;
      alphabet     = '0;
      accept_mask  = '0;
      errors       = 0;
    endfunction

    function int states_used();
      if (state_count < 1) return 1;
      if (state_count > DEF_MAX_STATES) return DEF_MAX_STATES;
      return int'(state_count);
    endfunction

    function int symbols_used();
      if (symbol_count < 1) return 1;
      if (symbol_count > DEF_MAX_SYMBOLS) return DEF_MAX_SYMBOLS;
      return int'(symbol_count);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STATE_COUNT:  state_count  = data[4:0];
        CFG_SYMBOL_COUNT: symbol_count = data[3:0];
        CFG_ALPHABET:     alphabet     = data;
        CFG_FINAL_MASK:   accept_mask  = data[15:0];
        default: ;
      endcase
    endfunction

    function void step_automaton(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] src,
                                 logic [SYM_W-1:0] sym, logic [TARGET_W-1:0] tgt,
                                 logic [CHAR_W-1:0] ch);
      int               n_st, n_sy, k, s, idx;
      bit               found;
      logic [SET_W-1:0] use_mask, next_set;
      nfa_result_t      r;
      n_st     = states_used();
      n_sy     = symbols_used();
      use_mask = SET_W'((33'd1 << n_st) - 1);
      r.status = ST_ACK;
      case (cmd)
        CMD_LOAD:  rows[int'(src) * DEF_MAX_SYMBOLS + int'(sym)] = tgt;
        CMD_START: begin
          active     = 16'h0001;
          string_bad = 1'b0;
        end
        CMD_SYMBOL: begin
          r.status = ST_UNKNOWN;
          if (!string_bad) begin
            found = 1'b0;
            idx   = 0;
            // The lowest matching index among the symbols in use wins.
            for (k = 0; k < n_sy && !found; k++) begin
              if (alphabet[8*k +: 8] == ch) begin
                found = 1'b1;
                idx   = k;
              end
            end
            if (!found) begin
              string_bad = 1'b1;
            end else begin
              next_set = '0;
              for (s = 0; s < n_st; s++) begin
                if (active[s]) next_set |= rows[s * DEF_MAX_SYMBOLS + idx];
              end
              active   = next_set & use_mask;
              r.status = ST_STEPPED;
            end
          end
        end
        default: begin
          if (string_bad) r.status = ST_INVALID;
          else if ((active & accept_mask & use_mask) != '0) r.status = ST_ACCEPTED;
          else r.status = ST_REJECTED;
        end
      endcase
      r.active_set = active;
      results_due.push_back(r);
    endfunction

    function void check_result(logic [SET_W-1:0] set_seen, logic [STATUS_W-1:0] status_seen);
      nfa_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: active_set %h status %0d",
                 $time, set_seen, status_seen);
        return;
      end
      want = results_due.pop_front();
      if (set_seen !== want.active_set) begin
        errors++;
        $display("%0t: active_set mismatch: expected %h actual %h",
                 $time, want.active_set, set_seen);
      end
      if (status_seen !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, status_seen);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  nfa_tracker board = new();
  int send_idle_pct = 21;
  int recv_idle_pct = 69;
  int items_sent    = 0;

  nfa_state_set_simulator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  // Called at a falling edge; returns at the falling edge after the transfer with
  // in_tvalid still high, so back-to-back commands keep it asserted.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] src,
                          input logic [SYM_W-1:0] sym, input logic [TARGET_W-1:0] tgt,
                          input logic [CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, ch, tgt, sym, src};
    do @(posedge clk); while (!in_tready);
    board.step_automaton(cmd, src, sym, tgt, ch);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers; count and final-mask writes sometimes carry junk above their width.
  task automatic write_config(input logic [4:0] sc, input logic [3:0] yc,
                              input logic [63:0] alpha, input logic [15:0] fm);
    logic [CFG_IDX_W-1:0]  order [4];
    logic [CFG_DATA_W-1:0] vals [4];
    logic [63:0]           junk;
    order = '{CFG_STATE_COUNT, CFG_SYMBOL_COUNT, CFG_ALPHABET, CFG_FINAL_MASK};
    junk  = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
    vals  = '{{junk[63:5], sc}, {junk[63:4], yc}, alpha, {junk[63:16], fm}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(order[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random setting, a batch of row loads, then strings of symbols.
  task automatic run_block();
    logic [4:0]          sc;
    logic [3:0]          yc;
    logic [63:0]         alpha;
    logic [15:0]         fm;
    logic [TARGET_W-1:0] tgt;
    logic [CHAR_W-1:0]   ch;
    int                  n_st, n_sy, n_loads, n_strings, len, r, k, b;
    wait_drained();
    r  = $urandom_range(0, 9);
    sc = 5'((r == 0) ? $urandom_range(0, 31) : (r == 1) ? 16 : (r == 2) ? 1 :
            $urandom_range(2, 16));
    r  = $urandom_range(0, 9);
    yc = 4'((r == 0) ? $urandom_range(0, 15) : (r == 1) ? 8 : (r == 2) ? 1 :
            $urandom_range(1, 8));
    for (b = 0; b < 8; b++) begin
      if (b > 0 && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, b - 1);
        alpha[8*b +: 8] = alpha[8*k +: 8];
      end else begin
        alpha[8*b +: 8] = 8'($urandom_range(0, 255));
      end
    end
    r  = $urandom_range(0, 9);
    fm = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    write_config(sc, yc, alpha, fm);
    n_st = board.states_used();
    n_sy = board.symbols_used();

    n_loads = $urandom_range(4, 20);
    repeat (n_loads) begin
      r = $urandom_range(0, 9);
      if (r == 0) tgt = '0;
      else if (r == 1) tgt = TARGET_W'($urandom_range(0, 65535));
      else if (r == 2) tgt = '1;
      else begin
        tgt = TARGET_W'(1) << $urandom_range(0, n_st - 1);
        if (r > 6) tgt |= TARGET_W'(1) << $urandom_range(0, n_st - 1);
      end
      send_cmd(CMD_LOAD,
               SRC_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) :
                                                    $urandom_range(0, n_st - 1)),
               SYM_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) :
                                                    $urandom_range(0, n_sy - 1)),
               tgt, CHAR_W'($urandom));
    end

    n_strings = $urandom_range(3, 8);
    repeat (n_strings) begin
      if ($urandom_range(0, 11) == 0)
        send_cmd(CMD_W'($urandom), SRC_W'($urandom), SYM_W'($urandom),
                 TARGET_W'($urandom), CHAR_W'($urandom));
      if ($urandom_range(0, 9) != 0)
        send_cmd(CMD_START, SRC_W'($urandom), SYM_W'($urandom),
                 TARGET_W'($urandom), CHAR_W'($urandom));
      len = $urandom_range(0, 10);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 90) begin
          k  = $urandom_range(0, n_sy - 1);
          ch = alpha[8*k +: 8];
        end else if (r < 95) begin
          k  = $urandom_range(0, 7);
          ch = alpha[8*k +: 8];
        end else begin
          ch = CHAR_W'($urandom_range(0, 255));
        end
        send_cmd(CMD_SYMBOL, SRC_W'($urandom), SYM_W'($urandom), TARGET_W'($urandom), ch);
      end
      if ($urandom_range(0, 9) != 0)
        send_cmd(CMD_FINISH, SRC_W'($urandom), SYM_W'($urandom),
                 TARGET_W'($urandom), CHAR_W'($urandom));
    end
  endtask

  initial begin
    int send_plan [3];
    int recv_plan [3];
    int phase_end;
    send_plan = '{21, 69, 0};
    recv_plan = '{69, 21, 0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at their reset values: empty table, all-zero alphabet.
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_START, 4'hF, 3'd7, 16'hFFFF, 8'hFF);

    // Alphabet with a repeated character at indexes one and two.
    wait_drained();
    write_config(5'd16, 4'd8, 64'hFF45_4443_4241_4100, 16'h8004);
    send_cmd(CMD_LOAD, 4'd0, 3'd0, 16'hFFFF, 8'h00);
    send_cmd(CMD_LOAD, 4'd15, 3'd7, 16'h8000, 8'hFF);
    send_cmd(CMD_LOAD, 4'd0, 3'd1, 16'h0004, 8'h00);
    send_cmd(CMD_LOAD, 4'd2, 3'd7, 16'h8000, 8'h00);
    send_cmd(CMD_LOAD, 4'd2, 3'd2, 16'h0002, 8'h00);
    send_cmd(CMD_START, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h41);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'hFF);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'hFF);
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);
    // Unknown character, then a symbol that must be ignored, then an invalid finish.
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h7E);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h41);
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_START, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);

    // Three states and one symbol: targets past state two are dropped.
    wait_drained();
    write_config(5'd3, 4'd1, 64'hFF45_4443_4241_4100, 16'h0004);
    send_cmd(CMD_START, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h41);
    send_cmd(CMD_START, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);

    // Zero counts saturate to one.
    wait_drained();
    write_config(5'd0, 4'd0, 64'hFF45_4443_4241_4100, 16'hFFFE);
    send_cmd(CMD_START, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_SYMBOL, 4'd0, 3'd0, 16'h0000, 8'h00);
    send_cmd(CMD_FINISH, 4'd0, 3'd0, 16'h0000, 8'h00);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_plan[p];
      recv_idle_pct = recv_plan[p];
      phase_end     = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_end) run_block();
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
